// ----- design/dual_axis_stepper_pointer_assert.svh -----
// Assertion helpers for the blocks that check their own logic.
// Both expect signals named clk and rst_n in the scope of use.
`ifndef DUAL_AXIS_STEPPER_POINTER_ASSERT_SVH
`define DUAL_AXIS_STEPPER_POINTER_ASSERT_SVH

// Same-cycle implication.
`define DASP_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define DASP_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- design/dasp_pkg.sv -----
`default_nettype none

package dasp_pkg;

    typedef enum logic [1:0] {
        ACT_TICK = 2'd0,
        ACT_SET  = 2'd1,
        ACT_HOME = 2'd2,
        ACT_NONE = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_ALT_BACK = 3'd1,
        PH_ALT_SEEK = 3'd2,
        PH_AZ_BACK  = 3'd3,
        PH_AZ_SEEK  = 3'd4
    } phase_t;

    typedef enum logic [2:0] {
        REG_ALT_REV  = 3'd0,
        REG_AZ_REV   = 3'd1,
        REG_ALT_BACK = 3'd2,
        REG_ALT_SEEK = 3'd3,
        REG_AZ_BACK  = 3'd4,
        REG_AZ_SEEK  = 3'd5
    } cfg_idx_t;

    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = 13;
    localparam int REV_BITS       = 13;
    localparam int LIM_BITS       = 11;
    localparam int ALT_ANGLE_BITS = 15;
    localparam int AZ_ANGLE_BITS  = 16;

    localparam logic [REV_BITS-1:0] RST_ALT_REV  = 13'd7070;
    localparam logic [REV_BITS-1:0] RST_AZ_REV   = 13'd6405;
    localparam logic [LIM_BITS-1:0] RST_ALT_BACK = 11'd1000;
    localparam logic [LIM_BITS-1:0] RST_ALT_SEEK = 11'd2000;
    localparam logic [LIM_BITS-1:0] RST_AZ_BACK  = 11'd500;
    localparam logic [LIM_BITS-1:0] RST_AZ_SEEK  = 11'd1000;

    // Angles in hundredths of a degree
    localparam int HALF_TURN = 18000;
    localparam int FULL_TURN = 36000;

    // Goal = floor(rev * mag / FULL_TURN) by reciprocal multiply; exact for prod < 2^29
    localparam int MAG_BITS    = 16;
    localparam int PROD_BITS   = 29;
    localparam int RECIP_SHIFT = 45;
    localparam int QUOT_BITS   = 14;
    localparam int WIDE_BITS   = RECIP_SHIFT + QUOT_BITS;
    localparam longint unsigned RECIP_MUL =
        ((64'd1 << RECIP_SHIFT) + 64'(FULL_TURN) - 64'd1) / 64'(FULL_TURN);

    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_BITS   = 2;
    localparam int QCNT_BITS   = 3;

    typedef struct packed {
        logic [REV_BITS-1:0] alt_rev;
        logic [REV_BITS-1:0] az_rev;
        logic [LIM_BITS-1:0] alt_back;
        logic [LIM_BITS-1:0] alt_seek;
        logic [LIM_BITS-1:0] az_back;
        logic [LIM_BITS-1:0] az_seek;
    } cfg_t;

    typedef struct packed {
        action_t action;
        logic    alt_sw;
        logic    az_sw;
    } cmd_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_stat_t;

    typedef struct packed {
        logic busy;
        logic fault;
    } back_stat_t;

endpackage

`default_nettype wire

// ----- design/dasp_in_if.sv -----
`default_nettype none

interface dasp_in_if;
    logic        valid;
    logic        ready;
    logic [1:0]  action;
    logic [14:0] alt_angle;
    logic [15:0] az_angle;
    logic        alt_switch_level;
    logic        az_switch_level;

    modport source (
        output valid, action, alt_angle, az_angle, alt_switch_level, az_switch_level,
        input  ready
    );

    modport sink (
        input  valid, action, alt_angle, az_angle, alt_switch_level, az_switch_level,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/dasp_out_if.sv -----
`default_nettype none

interface dasp_out_if #(
    parameter int POSITION_BITS = 13
);
    logic                            valid;
    logic                            ready;
    logic                            alt_pulse;
    logic                            alt_direction;
    logic                            az_pulse;
    logic                            az_direction;
    logic signed [POSITION_BITS-1:0] alt_steps_now;
    logic signed [POSITION_BITS-1:0] az_steps_now;
    logic                            homing_busy;
    logic                            homing_failed;
    logic                            range_halted;

    modport source (
        output valid, alt_pulse, alt_direction, az_pulse, az_direction,
               alt_steps_now, az_steps_now, homing_busy, homing_failed, range_halted,
        input  ready
    );

    modport sink (
        input  valid, alt_pulse, alt_direction, az_pulse, az_direction,
               alt_steps_now, az_steps_now, homing_busy, homing_failed, range_halted,
        output ready
    );
endinterface

`default_nettype wire

// ----- design/dual_axis_stepper_pointer.sv -----
// Path: the edge that accepts a command loads the product register; the quotient
// register, the queue write and execute into the result register follow in that
// order, and a full queue or a low rsp.ready can hold any step along the way.
// Throughput: one transaction per cycle while rsp.ready allows, set by the execute stage.
// Reset (async, active low) restores default configuration, zero positions and
// goals, idle homing and a clear fault latch; there is no clearing pass.
`default_nettype none
`include "dual_axis_stepper_pointer_assert.svh"

module dual_axis_stepper_pointer #(
    parameter int POSITION_BITS = 13,
    parameter int COUNT_BITS    = 11
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dasp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dasp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    dasp_in_if.sink                             cmd,
    dasp_out_if.source                          rsp
);
    import dasp_pkg::*;

    cfg_t                            cfg;
    logic                            q_push;
    logic                            q_push_ok;
    cmd_t                            q_push_cmd;
    logic signed [POSITION_BITS-1:0] q_push_alt_goal;
    logic signed [POSITION_BITS-1:0] q_push_az_goal;
    logic                            q_pop;
    cmd_t                            q_head_cmd;
    logic signed [POSITION_BITS-1:0] q_head_alt_goal;
    logic signed [POSITION_BITS-1:0] q_head_az_goal;
    q_stat_t                         q_stat;
    back_stat_t                      back_stat;
    logic                            homing_rsp;
    logic                            dual_pulse;

    dasp_cfg_regs u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    dasp_front #(
        .POSITION_BITS (POSITION_BITS)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .cmd           (cmd),
        .push_ok       (q_push_ok),
        .push          (q_push),
        .push_cmd      (q_push_cmd),
        .push_alt_goal (q_push_alt_goal),
        .push_az_goal  (q_push_az_goal)
    );

    dasp_queue #(
        .POSITION_BITS (POSITION_BITS)
    ) u_queue (
        .clk           (clk),
        .rst_n         (rst_n),
        .push          (q_push),
        .push_cmd      (q_push_cmd),
        .push_alt_goal (q_push_alt_goal),
        .push_az_goal  (q_push_az_goal),
        .push_ok       (q_push_ok),
        .pop           (q_pop),
        .head_cmd      (q_head_cmd),
        .head_alt_goal (q_head_alt_goal),
        .head_az_goal  (q_head_az_goal),
        .stat          (q_stat)
    );

    dasp_back #(
        .POSITION_BITS (POSITION_BITS),
        .COUNT_BITS    (COUNT_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg           (cfg),
        .head_cmd      (q_head_cmd),
        .head_alt_goal (q_head_alt_goal),
        .head_az_goal  (q_head_az_goal),
        .q_stat        (q_stat),
        .pop           (q_pop),
        .stat          (back_stat),
        .rsp           (rsp)
    );

    assign homing_rsp = rsp.valid && rsp.homing_busy;
    assign dual_pulse = rsp.alt_pulse && rsp.az_pulse;

    `DASP_ASSERT_NOW(a_no_push_full, q_push, !q_stat.full, "queue written while full")
    `DASP_ASSERT_NOW(a_no_pop_empty, q_pop, !q_stat.empty, "queue read while empty")
    `DASP_ASSERT_NOW(a_one_axis_homing, homing_rsp, !dual_pulse, "both axes pulsed during homing")
    `DASP_ASSERT_NEXT(a_fault_sticky, back_stat.fault, back_stat.fault, "homing fault cleared")

endmodule

`default_nettype wire

// ----- design/dasp_cfg_regs.sv -----
`default_nettype none

module dasp_cfg_regs (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_we,
    input  logic [dasp_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [dasp_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    output dasp_pkg::cfg_t                      cfg
);
    import dasp_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.alt_rev  <= RST_ALT_REV;
            cfg_reg.az_rev   <= RST_AZ_REV;
            cfg_reg.alt_back <= RST_ALT_BACK;
            cfg_reg.alt_seek <= RST_ALT_SEEK;
            cfg_reg.az_back  <= RST_AZ_BACK;
            cfg_reg.az_seek  <= RST_AZ_SEEK;
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx_t'(cfg_index))
                REG_ALT_REV:  cfg_reg.alt_rev  <= cfg_data[REV_BITS-1:0];
                REG_AZ_REV:   cfg_reg.az_rev   <= cfg_data[REV_BITS-1:0];
                REG_ALT_BACK: cfg_reg.alt_back <= cfg_data[LIM_BITS-1:0];
                REG_ALT_SEEK: cfg_reg.alt_seek <= cfg_data[LIM_BITS-1:0];
                REG_AZ_BACK:  cfg_reg.az_back  <= cfg_data[LIM_BITS-1:0];
                REG_AZ_SEEK:  cfg_reg.az_seek  <= cfg_data[LIM_BITS-1:0];
                default:      cfg_reg          <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- design/dasp_front.sv -----
`default_nettype none

module dasp_front #(
    parameter int POSITION_BITS = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dasp_pkg::cfg_t                  cfg,
    dasp_in_if.sink                         cmd,
    input  logic                            push_ok,
    output logic                            push,
    output dasp_pkg::cmd_t                  push_cmd,
    output logic signed [POSITION_BITS-1:0] push_alt_goal,
    output logic signed [POSITION_BITS-1:0] push_az_goal
);
    import dasp_pkg::*;

    localparam int GW = (POSITION_BITS > QUOT_BITS ? POSITION_BITS : QUOT_BITS) + 1;
    localparam logic [GW-1:0] POS_MAX = GW'((64'd1 << (POSITION_BITS - 1)) - 64'd1);

    // Saturate a quotient with its sign into the position range
    function automatic logic signed [POSITION_BITS-1:0] to_goal(
        input logic [QUOT_BITS-1:0] q,
        input logic                 neg
    );
        logic [GW-1:0] qx;
        logic [GW-1:0] res;
        qx = GW'(q);
        if (!neg)
            res = (qx > POS_MAX) ? POS_MAX : qx;
        else if (qx > POS_MAX + GW'(1))
            res = ~POS_MAX;
        else
            res = GW'(0) - qx;
        return signed'(res[POSITION_BITS-1:0]);
    endfunction

    // Accept stage: fold the azimuth, take magnitudes, multiply by steps per rev
    logic                 flip;
    logic [15:0]          az_adj;
    logic signed [16:0]   alt_s;
    logic signed [16:0]   alt_adj;
    logic                 alt_neg;
    logic [MAG_BITS-1:0]  alt_mag;
    logic [PROD_BITS-1:0] alt_prod;
    logic [PROD_BITS-1:0] az_prod;
    cmd_t                 in_cmd;

    assign flip    = cmd.az_angle > AZ_ANGLE_BITS'(HALF_TURN);
    assign az_adj  = flip ? (cmd.az_angle - AZ_ANGLE_BITS'(HALF_TURN)) : cmd.az_angle;
    assign alt_s   = signed'({2'b00, cmd.alt_angle});
    assign alt_adj = flip ? (17'(HALF_TURN) - alt_s) : alt_s;
    assign alt_neg = alt_adj[16];
    assign alt_mag = alt_neg ? MAG_BITS'(-alt_adj) : MAG_BITS'(alt_adj);
    assign alt_prod = PROD_BITS'(cfg.alt_rev) * PROD_BITS'(alt_mag);
    assign az_prod  = PROD_BITS'(cfg.az_rev) * PROD_BITS'(az_adj);

    assign in_cmd.action = action_t'(cmd.action);
    assign in_cmd.alt_sw = cmd.alt_switch_level;
    assign in_cmd.az_sw  = cmd.az_switch_level;

    logic                 s1_v_reg;
    cmd_t                 s1_cmd_reg;
    logic                 s1_neg_reg;
    logic [PROD_BITS-1:0] s1_alt_prod_reg;
    logic [PROD_BITS-1:0] s1_az_prod_reg;

    logic                 s2_v_reg;
    cmd_t                 s2_cmd_reg;
    logic                 s2_neg_reg;
    logic [QUOT_BITS-1:0] s2_alt_q_reg;
    logic [QUOT_BITS-1:0] s2_az_q_reg;

    logic                 s1_load;
    logic                 s2_load;
    logic [WIDE_BITS-1:0] alt_wide;
    logic [WIDE_BITS-1:0] az_wide;

    assign s2_load   = !s2_v_reg || push_ok;
    assign s1_load   = !s1_v_reg || s2_load;
    assign cmd.ready = s1_load;

    assign alt_wide = WIDE_BITS'(s1_alt_prod_reg) * WIDE_BITS'(RECIP_MUL);
    assign az_wide  = WIDE_BITS'(s1_az_prod_reg) * WIDE_BITS'(RECIP_MUL);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_v_reg <= 1'b0;
            s2_v_reg <= 1'b0;
        end
        else
        begin
            if (s1_load)
                s1_v_reg <= cmd.valid;
            if (s2_load)
                s2_v_reg <= s1_v_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_load)
        begin
            s1_cmd_reg      <= in_cmd;
            s1_neg_reg      <= alt_neg;
            s1_alt_prod_reg <= alt_prod;
            s1_az_prod_reg  <= az_prod;
        end
        if (s2_load)
        begin
            s2_cmd_reg   <= s1_cmd_reg;
            s2_neg_reg   <= s1_neg_reg;
            s2_alt_q_reg <= alt_wide[RECIP_SHIFT +: QUOT_BITS];
            s2_az_q_reg  <= az_wide[RECIP_SHIFT +: QUOT_BITS];
        end
    end

    assign push          = s2_v_reg && push_ok;
    assign push_cmd      = s2_cmd_reg;
    assign push_alt_goal = to_goal(s2_alt_q_reg, s2_neg_reg);
    assign push_az_goal  = to_goal(s2_az_q_reg, 1'b0);

endmodule

`default_nettype wire

// ----- design/dasp_queue.sv -----
`default_nettype none

module dasp_queue #(
    parameter int POSITION_BITS = 13
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            push,
    input  dasp_pkg::cmd_t                  push_cmd,
    input  logic signed [POSITION_BITS-1:0] push_alt_goal,
    input  logic signed [POSITION_BITS-1:0] push_az_goal,
    output logic                            push_ok,
    input  logic                            pop,
    output dasp_pkg::cmd_t                  head_cmd,
    output logic signed [POSITION_BITS-1:0] head_alt_goal,
    output logic signed [POSITION_BITS-1:0] head_az_goal,
    output dasp_pkg::q_stat_t               stat
);
    import dasp_pkg::*;

    cmd_t                            cmd_q   [QUEUE_DEPTH];
    logic signed [POSITION_BITS-1:0] alt_q   [QUEUE_DEPTH];
    logic signed [POSITION_BITS-1:0] az_q    [QUEUE_DEPTH];

    logic [QPTR_BITS-1:0] wr_ptr_reg;
    logic [QPTR_BITS-1:0] rd_ptr_reg;
    logic [QCNT_BITS-1:0] count_reg;
    logic [QCNT_BITS-1:0] count_next;

    assign stat.full  = count_reg == QCNT_BITS'(QUEUE_DEPTH);
    assign stat.empty = count_reg == '0;
    assign push_ok    = !stat.full;

    always_comb
    begin
        unique case ({push, pop})
            2'b10:   count_next = count_reg + QCNT_BITS'(1);
            2'b01:   count_next = count_reg - QCNT_BITS'(1);
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= wr_ptr_reg + QPTR_BITS'(1);
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + QPTR_BITS'(1);
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            cmd_q[wr_ptr_reg] <= push_cmd;
            alt_q[wr_ptr_reg] <= push_alt_goal;
            az_q[wr_ptr_reg]  <= push_az_goal;
        end
    end

    assign head_cmd      = cmd_q[rd_ptr_reg];
    assign head_alt_goal = alt_q[rd_ptr_reg];
    assign head_az_goal  = az_q[rd_ptr_reg];

endmodule

`default_nettype wire

// ----- design/dasp_back.sv -----
`default_nettype none

module dasp_back #(
    parameter int POSITION_BITS = 13,
    parameter int COUNT_BITS    = 11
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  dasp_pkg::cfg_t                  cfg,
    input  dasp_pkg::cmd_t                  head_cmd,
    input  logic signed [POSITION_BITS-1:0] head_alt_goal,
    input  logic signed [POSITION_BITS-1:0] head_az_goal,
    input  dasp_pkg::q_stat_t               q_stat,
    output logic                            pop,
    output dasp_pkg::back_stat_t            stat,
    dasp_out_if.source                      rsp
);
    import dasp_pkg::*;

    localparam int RW = (POSITION_BITS > REV_BITS ? POSITION_BITS : REV_BITS) + 1;
    localparam int LW = (COUNT_BITS > LIM_BITS ? COUNT_BITS : LIM_BITS);
    localparam logic [LW-1:0] CNT_MAX = LW'((64'd1 << COUNT_BITS) - 64'd1);

    function automatic logic out_of_range(
        input logic signed [POSITION_BITS-1:0] a,
        input logic signed [POSITION_BITS-1:0] z,
        input logic [REV_BITS-1:0]             arev,
        input logic [REV_BITS-1:0]             zrev
    );
        logic signed [RW-1:0] ax;
        logic signed [RW-1:0] zx;
        logic signed [RW-1:0] ah;
        logic signed [RW-1:0] zh;
        ax = RW'(a);
        zx = RW'(z);
        ah = signed'(RW'(arev >> 1));
        zh = signed'(RW'(zrev >> 1));
        return (ax > ah) || (ax < -ah) || (zx > zh) || (zx < -zh);
    endfunction

    function automatic logic [COUNT_BITS-1:0] cap_count(input logic [LIM_BITS-1:0] v);
        logic [LW-1:0] vx;
        vx = LW'(v);
        return (vx > CNT_MAX) ? COUNT_BITS'(CNT_MAX) : COUNT_BITS'(vx);
    endfunction

    function automatic phase_t next_phase(input phase_t ph);
        phase_t r;
        unique case (ph)
            PH_ALT_BACK: r = PH_ALT_SEEK;
            PH_ALT_SEEK: r = PH_AZ_BACK;
            PH_AZ_BACK:  r = PH_AZ_SEEK;
            default:     r = PH_IDLE;
        endcase
        return r;
    endfunction

    logic signed [POSITION_BITS-1:0] alt_pos_reg, alt_pos_next;
    logic signed [POSITION_BITS-1:0] az_pos_reg, az_pos_next;
    logic signed [POSITION_BITS-1:0] alt_goal_reg, alt_goal_next;
    logic signed [POSITION_BITS-1:0] az_goal_reg, az_goal_next;
    phase_t                          phase_reg, phase_next;
    logic [COUNT_BITS-1:0]           count_reg, count_next;
    logic                            fault_reg, fault_next;

    logic                            out_v_reg;
    logic                            alt_pulse_reg, alt_dir_reg;
    logic                            az_pulse_reg, az_dir_reg;
    logic signed [POSITION_BITS-1:0] alt_now_reg, az_now_reg;
    logic                            busy_reg, failed_reg, halted_reg;

    logic                  take;
    logic                  is_tick;
    logic                  backing;
    logic                  seeking;
    logic                  on_az;
    logic                  sw;
    logic [COUNT_BITS-1:0] back_lim;
    logic [COUNT_BITS-1:0] seek_lim;
    logic                  cnt_lt_back;
    logic                  cnt_lt_seek;
    logic                  hom_pulse;
    logic                  oor_now;
    logic                  oor_next;
    logic                  ap, ad, zp, zd;

    assign take    = !q_stat.empty && (!out_v_reg || rsp.ready);
    assign pop     = take;
    assign is_tick = head_cmd.action == ACT_TICK;
    assign backing = (phase_reg == PH_ALT_BACK) || (phase_reg == PH_AZ_BACK);
    assign seeking = (phase_reg == PH_ALT_SEEK) || (phase_reg == PH_AZ_SEEK);
    assign on_az   = (phase_reg == PH_AZ_BACK) || (phase_reg == PH_AZ_SEEK);
    assign sw      = on_az ? head_cmd.az_sw : head_cmd.alt_sw;
    assign back_lim = cap_count(on_az ? cfg.az_back : cfg.alt_back);
    assign seek_lim = cap_count(on_az ? cfg.az_seek : cfg.alt_seek);
    assign cnt_lt_back = count_reg < back_lim;
    assign cnt_lt_seek = count_reg < seek_lim;
    assign hom_pulse   = (backing && cnt_lt_back) || (seeking && sw && cnt_lt_seek);

    assign oor_now  = out_of_range(alt_pos_reg, az_pos_reg, cfg.alt_rev, cfg.az_rev);
    assign oor_next = out_of_range(alt_pos_next, az_pos_next, cfg.alt_rev, cfg.az_rev);

    // Homing sequencer and goal registers
    always_comb
    begin
        phase_next    = phase_reg;
        count_next    = count_reg;
        fault_next    = fault_reg;
        alt_goal_next = alt_goal_reg;
        az_goal_next  = az_goal_reg;
        if (take)
        begin
            unique case (head_cmd.action)
                ACT_SET:
                begin
                    alt_goal_next = head_alt_goal;
                    az_goal_next  = head_az_goal;
                end
                ACT_HOME:
                begin
                    phase_next = PH_ALT_BACK;
                    count_next = '0;
                end
                ACT_TICK:
                begin
                    if (backing)
                    begin
                        if (cnt_lt_back)
                            count_next = count_reg + COUNT_BITS'(1);
                        else
                        begin
                            phase_next = next_phase(phase_reg);
                            count_next = '0;
                        end
                    end
                    else if (seeking)
                    begin
                        if (sw && cnt_lt_seek)
                            count_next = count_reg + COUNT_BITS'(1);
                        else
                        begin
                            // switch never reached within the limit
                            if (sw)
                                fault_next = 1'b1;
                            phase_next = next_phase(phase_reg);
                            count_next = '0;
                        end
                    end
                end
                ACT_NONE:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end
    end

    // Pulses and position tracking
    always_comb
    begin
        ap           = 1'b0;
        ad           = 1'b0;
        zp           = 1'b0;
        zd           = 1'b0;
        alt_pos_next = alt_pos_reg;
        az_pos_next  = az_pos_reg;
        if (take && is_tick)
        begin
            if (phase_reg != PH_IDLE)
            begin
                // homing pulses leave the position counters alone
                if (on_az)
                begin
                    zp = hom_pulse;
                    zd = hom_pulse && seeking;
                end
                else
                begin
                    ap = hom_pulse;
                    ad = hom_pulse && seeking;
                end
            end
            else if (!oor_now)
            begin
                if (alt_pos_reg != alt_goal_reg)
                begin
                    ap = 1'b1;
                    ad = !(alt_pos_reg < alt_goal_reg);
                    alt_pos_next = ad ? (alt_pos_reg - POSITION_BITS'(1))
                                      : (alt_pos_reg + POSITION_BITS'(1));
                end
                if (az_pos_reg != az_goal_reg)
                begin
                    zp = 1'b1;
                    zd = !(az_pos_reg < az_goal_reg);
                    az_pos_next = zd ? (az_pos_reg - POSITION_BITS'(1))
                                     : (az_pos_reg + POSITION_BITS'(1));
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            alt_pos_reg  <= '0;
            az_pos_reg   <= '0;
            alt_goal_reg <= '0;
            az_goal_reg  <= '0;
            phase_reg    <= PH_IDLE;
            count_reg    <= '0;
            fault_reg    <= 1'b0;
            out_v_reg    <= 1'b0;
        end
        else
        begin
            alt_pos_reg  <= alt_pos_next;
            az_pos_reg   <= az_pos_next;
            alt_goal_reg <= alt_goal_next;
            az_goal_reg  <= az_goal_next;
            phase_reg    <= phase_next;
            count_reg    <= count_next;
            fault_reg    <= fault_next;
            if (take)
                out_v_reg <= 1'b1;
            else if (rsp.ready)
                out_v_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            alt_pulse_reg <= ap;
            alt_dir_reg   <= ad;
            az_pulse_reg  <= zp;
            az_dir_reg    <= zd;
            alt_now_reg   <= alt_pos_next;
            az_now_reg    <= az_pos_next;
            busy_reg      <= phase_next != PH_IDLE;
            failed_reg    <= fault_next;
            halted_reg    <= oor_next;
        end
    end

    assign rsp.valid         = out_v_reg;
    assign rsp.alt_pulse     = alt_pulse_reg;
    assign rsp.alt_direction = alt_dir_reg;
    assign rsp.az_pulse      = az_pulse_reg;
    assign rsp.az_direction  = az_dir_reg;
    assign rsp.alt_steps_now = alt_now_reg;
    assign rsp.az_steps_now  = az_now_reg;
    assign rsp.homing_busy   = busy_reg;
    assign rsp.homing_failed = failed_reg;
    assign rsp.range_halted  = halted_reg;

    assign stat.busy  = phase_reg != PH_IDLE;
    assign stat.fault = fault_reg;

endmodule

`default_nettype wire
